@@ rtl/sacl_pkg.sv @@
package sacl_pkg;

    // default sizes of the tag store
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_BITS_DEF    = 64;

    // fixed field widths
    localparam int AGE_W       = 4;
    localparam int CNT_W       = 32;
    localparam int OP_W        = 2;
    localparam int IN_ADDR_W   = 64;
    localparam int SET_BITS_W  = 3;
    localparam int WAYS_W      = 4;
    localparam int OFFSET_W    = 6;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 4;
    localparam int REG_IDX_W   = 2;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register map indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SET_BITS = 2'd0,
        REG_WAYS     = 2'd1,
        REG_OFFSET   = 2'd2
    } t_reg_idx;

    // access kinds
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    // control state of the access sequencer
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

    // configuration register contents
    typedef struct packed {
        logic [SET_BITS_W-1:0] set_bits;
        logic [WAYS_W-1:0]     ways_in_use;
        logic [OFFSET_W-1:0]   offset_bits;
    } t_cfg;

    // lookup status handed to the sequencer
    typedef struct packed {
        logic hit;
        logic evict;
    } t_lkp_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                 input logic en);
        logic [CNT_W-1:0] r;
        r = v;
        if (en && v != CNT_MAX) begin
            r = v + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/sacl_if.sv @@
// request channel: one access per transaction
interface sacl_req_if;
    import sacl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [IN_ADDR_W-1:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

// response channel: one result per access
interface sacl_rsp_if;
    import sacl_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;

    modport source (output valid, output outcome, output extra_hit, output hit_total,
                    output miss_total, output eviction_total, input ready);
    modport sink   (input valid, input outcome, input extra_hit, input hit_total,
                    input miss_total, input eviction_total, output ready);
endinterface

@@ rtl/sacl_ram.sv @@
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sacl_cfg.sv @@
module sacl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [sacl_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [sacl_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                           o_pready,
    output sacl_pkg::t_cfg                 o_cfg
);
    import sacl_pkg::*;

    t_cfg             r_cfg;
    logic             wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx  = i_paddr[PADDR_W-1:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits    <= '0;
            r_cfg.ways_in_use <= WAYS_W'(1);
            r_cfg.offset_bits <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SET_BITS: r_cfg.set_bits    <= i_pwdata[SET_BITS_W-1:0];
                REG_WAYS:     r_cfg.ways_in_use <= i_pwdata[WAYS_W-1:0];
                REG_OFFSET:   r_cfg.offset_bits <= i_pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_SET_BITS: o_prdata = APB_DATA_W'(r_cfg.set_bits);
            REG_WAYS:     o_prdata = APB_DATA_W'(r_cfg.ways_in_use);
            REG_OFFSET:   o_prdata = APB_DATA_W'(r_cfg.offset_bits);
            default:      o_prdata = '0;
        endcase
    end

endmodule

@@ rtl/sacl_lookup.sv @@
module sacl_lookup #(
    parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF,
    parameter int ROW_W     = MAX_WAYS * (1 + sacl_pkg::AGE_W + ADDR_BITS)
) (
    input  logic [ROW_W-1:0]     i_row,
    input  logic [ADDR_BITS-1:0] i_tag,
    input  logic [MAX_WAYS-1:0]  i_way_en,
    output logic [ROW_W-1:0]     o_row,
    output sacl_pkg::t_lkp_res   o_res
);
    import sacl_pkg::*;

    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_LO = MAX_WAYS;
    localparam int TAG_LO = MAX_WAYS * (1 + AGE_W);

    logic [MAX_WAYS-1:0]  valid;
    logic [AGE_W-1:0]     age   [MAX_WAYS];
    logic [ADDR_BITS-1:0] tag   [MAX_WAYS];
    logic [MAX_WAYS-1:0]  n_valid;
    logic [AGE_W-1:0]     n_age [MAX_WAYS];
    logic [ADDR_BITS-1:0] n_tag [MAX_WAYS];

    logic             hit_found;
    logic             empty_found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] empty_way;
    logic [WAY_W-1:0] old_way;
    logic [AGE_W-1:0] best_age;
    logic [WAY_W-1:0] sel_way;
    logic [AGE_W:0]   limit;

    // unpack the set row
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            valid[i] = i_row[i];
            age[i]   = i_row[AGE_LO + i*AGE_W +: AGE_W];
            tag[i]   = i_row[TAG_LO + i*ADDR_BITS +: ADDR_BITS];
        end
    end

    // tag match (lowest way) and free way (highest way)
    always_comb begin
        hit_found   = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i_way_en[i] && valid[i] && tag[i] == i_tag && !hit_found) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(i);
            end
            if (i_way_en[i] && !valid[i]) begin
                empty_found = 1'b1;
                empty_way   = WAY_W'(i);
            end
        end
    end

    // oldest way, ties go to the higher way
    always_comb begin
        best_age = '0;
        old_way  = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i_way_en[i] && age[i] >= best_age) begin
                best_age = age[i];
                old_way  = WAY_W'(i);
            end
        end
    end

    // chosen way and ageing bound
    always_comb begin
        if (hit_found) begin
            sel_way = hit_way;
            limit   = {1'b0, age[hit_way]};
        end else begin
            sel_way = empty_found ? empty_way : old_way;
            limit   = {1'b1, {AGE_W{1'b0}}};
        end
    end

    // lru update of the whole set
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            n_valid[i] = valid[i];
            n_age[i]   = age[i];
            n_tag[i]   = tag[i];
            if (WAY_W'(i) == sel_way) begin
                n_valid[i] = 1'b1;
                n_age[i]   = AGE_W'(1);
                n_tag[i]   = i_tag;
            end else if (i_way_en[i] && valid[i] && {1'b0, age[i]} < limit
                         && age[i] != AGE_MAX) begin
                n_age[i] = age[i] + AGE_W'(1);
            end
        end
    end

    // pack the new row
    always_comb begin
        o_row = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            o_row[i]                                = n_valid[i];
            o_row[AGE_LO + i*AGE_W +: AGE_W]        = n_age[i];
            o_row[TAG_LO + i*ADDR_BITS +: ADDR_BITS] = n_tag[i];
        end
    end

    assign o_res.hit   = hit_found;
    assign o_res.evict = !hit_found && !empty_found;

endmodule

@@ rtl/set_assoc_cache_lru_sim_unit.sv @@
// Tag store of a set-associative cache with true LRU replacement. Each request
// transaction carries an operation and a byte address; the block answers with one
// response transaction giving hit, fill or eviction, a flag for the extra store hit
// of a modify, and the saturating hit, miss and eviction totals after that access.
// One set row (valid bits, ages and tags of all ways) lives in a single-port-write,
// registered-read tag RAM. An access first reads the set row, then compares all
// ways in parallel, updates the ages and writes the row back; the next request is
// taken in the cycle after write-back. A response not yet taken holds the access
// in its compare cycle until the response register frees. After reset the RAM is
// cleared one row per cycle, all 2**MAX_SET_BITS rows (64 by default), during
// which no request is taken; register writes over the APB port work throughout.
module set_assoc_cache_lru_sim_unit #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS    = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [sacl_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [sacl_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                            o_pready,
    sacl_req_if.sink                        i_req,
    sacl_rsp_if.source                      o_rsp
);
    import sacl_pkg::*;

    localparam int DEPTH  = 2 ** MAX_SET_BITS;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROW_W  = MAX_WAYS * (1 + AGE_W + ADDR_BITS);
    localparam int WC_W   = 5;
    localparam int SH_W   = 7;
    localparam int SB_W   = 4;

    t_cfg cfg;

    t_state               r_state;
    logic [SET_W-1:0]     r_clr_idx;
    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic [OP_W-1:0]      r_op;

    logic [CNT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_miss_cnt;
    logic [CNT_W-1:0] r_evict_cnt;
    logic [CNT_W-1:0] n_hit_cnt;
    logic [CNT_W-1:0] n_miss_cnt;
    logic [CNT_W-1:0] n_evict_cnt;

    logic     r_out_valid;
    t_outcome r_outcome;
    logic     r_extra;

    logic                 req_take;
    logic                 commit;
    logic [ADDR_BITS-1:0] addr_m;
    logic [SB_W-1:0]      sb;
    logic [SH_W-1:0]      tag_sh;
    logic [ADDR_BITS-1:0] set_sh;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag_val;
    logic [WC_W-1:0]      way_cnt;
    logic [MAX_WAYS-1:0]  way_en;
    logic                 is_modify;

    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] new_row;
    t_lkp_res         lkp;

    // configuration registers
    sacl_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // handshake
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign commit      = (r_state == ST_LOOKUP) && (!r_out_valid || o_rsp.ready);

    // set index and tag from the address
    always_comb begin
        addr_m = i_req.address[ADDR_BITS-1:0];
        sb     = ({1'b0, cfg.set_bits} > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                              : {1'b0, cfg.set_bits};
        set_sh = ({1'b0, cfg.offset_bits} >= SH_W'(ADDR_BITS)) ? '0
                                                               : addr_m >> cfg.offset_bits;
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (SB_W'(i) < sb);
        end
        set_idx = set_sh[SET_W-1:0] & set_mask;
        tag_sh  = SH_W'(cfg.offset_bits) + SH_W'(sb);
        tag_val = (tag_sh >= SH_W'(ADDR_BITS)) ? '0 : addr_m >> tag_sh;
    end

    // ways taking part in lookup and replacement
    always_comb begin
        if (cfg.ways_in_use == '0) begin
            way_cnt = WC_W'(1);
        end else if ({1'b0, cfg.ways_in_use} > WC_W'(MAX_WAYS)) begin
            way_cnt = WC_W'(MAX_WAYS);
        end else begin
            way_cnt = {1'b0, cfg.ways_in_use};
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            way_en[i] = (WC_W'(i) < way_cnt);
        end
    end

    // tag ram write port: clearing pass or write-back
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else begin
            ram_we    = commit;
            ram_waddr = r_set;
            ram_wdata = new_row;
        end
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH),
        .AW    (SET_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (req_take),
        .i_raddr (set_idx),
        .o_rdata (ram_rdata)
    );

    sacl_lookup #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .ROW_W     (ROW_W)
    ) u_lookup (
        .i_row    (ram_rdata),
        .i_tag    (r_tag),
        .i_way_en (way_en),
        .o_row    (new_row),
        .o_res    (lkp)
    );

    // counter updates for the access in flight
    assign is_modify = (r_op == OP_MODIFY);
    always_comb begin
        n_hit_cnt   = sat_inc(sat_inc(r_hit_cnt, lkp.hit), is_modify);
        n_miss_cnt  = sat_inc(r_miss_cnt, !lkp.hit);
        n_evict_cnt = sat_inc(r_evict_cnt, lkp.evict);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + SET_W'(1);
                    if (r_clr_idx == SET_W'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (req_take) begin
                        r_state <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    // captured request
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_set <= set_idx;
            r_tag <= tag_val;
            r_op  <= i_req.operation;
        end
    end

    // running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (commit) begin
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_evict_cnt <= n_evict_cnt;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_outcome <= lkp.hit ? OUT_HIT : (lkp.evict ? OUT_EVICT : OUT_FILL);
            r_extra   <= is_modify;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.outcome        = r_outcome;
    assign o_rsp.extra_hit      = r_extra;
    assign o_rsp.hit_total      = r_hit_cnt;
    assign o_rsp.miss_total     = r_miss_cnt;
    assign o_rsp.eviction_total = r_evict_cnt;

    // no request taken during the clearing pass
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_req.ready)
        else $error("request taken during tag ram clearing");

    // an accepted request always moves to the compare cycle
    a_take_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> (r_state == ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    // a write-back always yields a pending response
    a_wb_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("write-back without response");

    // totals never decrease
    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hit_cnt >= $past(r_hit_cnt)
                            && r_miss_cnt >= $past(r_miss_cnt)
                            && r_evict_cnt >= $past(r_evict_cnt)))
        else $error("saturating counter went backwards");

endmodule
